// File: src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants, types and the crc update for the stuffed frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int MAX_PAYLOAD_BYTES = 64;
    localparam int ADDR_W            = $clog2(MAX_PAYLOAD_BYTES);
    localparam int CNT_W             = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int LEN_W             = 7;
    localparam int CFG_IDX_W         = 2;
    localparam int TDATA_W           = 32;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  STUFF_XOR = 8'h20;

    localparam logic [7:0] MARK1_RESET = 8'd170;
    localparam logic [7:0] MARK2_RESET = 8'd85;
    localparam logic [7:0] ESC_RESET   = 8'd125;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARK1 = 2'd0,
        CFG_MARK2 = 2'd1,
        CFG_ESC   = 2'd2
    } cfg_idx_t;

    // handoff from the parser to the result sequencer
    typedef struct packed {
        logic             start;
        logic [7:0]       frame_type;
        logic [7:0]       frame_seq;
        logic [CNT_W-1:0] count;
    } emit_req_t;

    // one byte of crc16-ccitt, msb first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// frame hunt, header capture, unstuffing into the payload ram and crc check
// ----------------------------------------------------------------------------
module sfd_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [7:0]               in_byte,
    input  logic [7:0]               mark1,
    input  logic [7:0]               mark2,
    input  logic [7:0]               esc,
    output logic                     wr_en,
    output logic [sfd_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]               wr_data,
    output sfd_pkg::emit_req_t       req
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1, PH_HUNT2, PH_TYPE, PH_LEN, PH_SEQ, PH_BODY, PH_CRCL, PH_CRCH
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       slen_reg, slen_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       body_reg, body_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crcl_reg, crcl_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] ucnt_reg, ucnt_next;
    logic             over_reg, over_next;
    emit_req_t        req_reg, req_next;

    logic             accept;
    logic [15:0]      crc_fed;
    logic             body_last;
    logic             store;
    logic [7:0]       store_val;

    assign accept    = in_valid && in_ready;
    assign crc_fed   = crc16_feed(crc_reg, in_byte);
    assign body_last = ({1'b0, body_reg} + 9'd1) >= {1'b0, slen_reg};

    // at most one payload byte is produced per stuffed byte
    always_comb begin
        store     = 1'b0;
        store_val = in_byte;
        if (pend_reg) begin
            store     = 1'b1;
            store_val = in_byte ^ STUFF_XOR;
        end else if (in_byte == esc) begin
            store     = body_last;
            store_val = esc;
        end else begin
            store     = 1'b1;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        slen_next  = slen_reg;
        seq_next   = seq_reg;
        body_next  = body_reg;
        crc_next   = crc_reg;
        crcl_next  = crcl_reg;
        pend_next  = pend_reg;
        ucnt_next  = ucnt_reg;
        over_next  = over_reg;
        req_next   = '{start: 1'b0, frame_type: type_reg, frame_seq: seq_reg,
                       count: ucnt_reg};
        wr_en      = 1'b0;
        wr_addr    = ucnt_reg[ADDR_W-1:0];
        wr_data    = store_val;
        if (accept) begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (in_byte == mark1) begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (in_byte == mark2) begin
                        phase_next = PH_TYPE;
                        body_next  = '0;
                        crc_next   = CRC_INIT;
                        pend_next  = 1'b0;
                        ucnt_next  = '0;
                        over_next  = 1'b0;
                    end else if (in_byte != mark1) begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_TYPE: begin
                    type_next  = in_byte;
                    crc_next   = crc_fed;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    slen_next  = in_byte;
                    crc_next   = crc_fed;
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next   = in_byte;
                    crc_next   = crc_fed;
                    phase_next = (slen_reg == 8'd0) ? PH_CRCL : PH_BODY;
                end
                PH_BODY: begin
                    crc_next  = crc_fed;
                    body_next = body_reg + 8'd1;
                    pend_next = !pend_reg && (in_byte == esc) && !body_last;
                    if (store && !over_reg) begin
                        if (ucnt_reg >= CNT_W'(MAX_PAYLOAD_BYTES)) begin
                            over_next = 1'b1;
                        end else begin
                            wr_en     = 1'b1;
                            ucnt_next = ucnt_reg + CNT_W'(1);
                        end
                    end
                    if (body_last) begin
                        phase_next = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    crcl_next  = in_byte;
                    phase_next = PH_CRCH;
                end
                PH_CRCH: begin
                    phase_next     = PH_HUNT1;
                    req_next.start = ({in_byte, crcl_reg} == crc_reg) && !over_reg;
                end
                default: phase_next = PH_HUNT1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT1;
            pend_reg      <= 1'b0;
            over_reg      <= 1'b0;
            ucnt_reg      <= '0;
            body_reg      <= '0;
            crc_reg       <= CRC_INIT;
            req_reg.start <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            over_reg      <= over_next;
            ucnt_reg      <= ucnt_next;
            body_reg      <= body_next;
            crc_reg       <= crc_next;
            req_reg.start <= req_next.start;
        end
        type_reg           <= type_next;
        slen_reg           <= slen_next;
        seq_reg            <= seq_next;
        crcl_reg           <= crcl_next;
        req_reg.frame_type <= req_next.frame_type;
        req_reg.frame_seq  <= req_next.frame_seq;
        req_reg.count      <= req_next.count;
    end

    assign req = req_reg;

endmodule

// File: src/sfd_emit.sv
// ----------------------------------------------------------------------------
// sfd_emit
// reads the payload ram back and drives the result register
// ----------------------------------------------------------------------------
module sfd_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sfd_pkg::emit_req_t         req,
    output logic                       busy,
    output logic                       rd_en,
    output logic [sfd_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_type,
    output logic [7:0]                 out_seq,
    output logic [sfd_pkg::LEN_W-1:0]  out_len,
    output logic [7:0]                 out_byte,
    output logic                       out_bvalid,
    output logic                       out_last
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {EM_IDLE, EM_READ, EM_LOAD, EM_SHOW} em_state_t;

    em_state_t         state_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [7:0]        type_reg, seq_reg, byte_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              valid_reg, bvalid_reg, last_reg;
    logic              idx_last;

    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                EM_IDLE: begin
                    if (req.start) begin
                        type_reg <= req.frame_type;
                        seq_reg  <= req.frame_seq;
                        cnt_reg  <= req.count;
                        idx_reg  <= '0;
                        if (req.count == '0) begin
                            byte_reg   <= '0;
                            bvalid_reg <= 1'b0;
                            last_reg   <= 1'b1;
                            valid_reg  <= 1'b1;
                            state_reg  <= EM_SHOW;
                        end else begin
                            state_reg <= EM_READ;
                        end
                    end
                end
                EM_READ: state_reg <= EM_LOAD;
                EM_LOAD: begin
                    byte_reg   <= rd_data;
                    bvalid_reg <= 1'b1;
                    last_reg   <= idx_last;
                    valid_reg  <= 1'b1;
                    state_reg  <= EM_SHOW;
                end
                EM_SHOW: begin
                    if (out_ready) begin
                        valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= EM_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + ADDR_W'(1);
                            state_reg <= EM_READ;
                        end
                    end
                end
                default: state_reg <= EM_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != EM_IDLE);
    assign rd_en      = (state_reg == EM_READ);
    assign rd_addr    = idx_reg;
    assign out_valid  = valid_reg;
    assign out_type   = type_reg;
    assign out_seq    = seq_reg;
    assign out_len    = LEN_W'(cnt_reg);
    assign out_byte   = byte_reg;
    assign out_bvalid = bvalid_reg;
    assign out_last   = last_reg;

endmodule

// File: src/stuffed_crc_frame_decoder.sv
// ----------------------------------------------------------------------------
// stuffed_crc_frame_decoder
// byte-stuffed frame decoder with crc16-ccitt check and payload replay
// ----------------------------------------------------------------------------
// one input item per cycle while hunting, reading a header, payload or crc
// after the crc high byte of a good frame, input stalls while the payload
// replays from the ram: each result goes through read, load and show, and
// show holds through sink stalls; an empty frame goes straight to show
// bad or overlong frames give no result and do not stall the input
// aresetn (sync, active low) restores default markers and hunts for a frame
// ----------------------------------------------------------------------------
module stuffed_crc_frame_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] in_byte
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] frame_type, [15:8] frame_seq, [22:16] payload_len,
    // [30:23] payload_byte, [31] zero
    output logic [sfd_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tuser,   // [0] byte_valid
    output logic                               m_tlast,   // last_of_frame
    // configuration writes
    input  logic                               cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                         cfg_wdata
);
    import sfd_pkg::*;

    logic [7:0] mark1_reg, mark2_reg, esc_reg;

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark1_reg <= MARK1_RESET;
            mark2_reg <= MARK2_RESET;
            esc_reg   <= ESC_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MARK1: mark1_reg <= cfg_wdata;
                CFG_MARK2: mark2_reg <= cfg_wdata;
                CFG_ESC:   esc_reg   <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    emit_req_t         req;
    logic              busy;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;
    logic [7:0]        out_type, out_seq, out_byte;
    logic [LEN_W-1:0]  out_len;
    logic              out_bvalid, out_last;

    // input is held off for the whole replay, so ram writes and reads
    // never touch the same entry in the same cycle
    assign s_tready = !busy;

    // header, unstuffing and crc check; payload goes to the ram
    sfd_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .mark1    (mark1_reg),
        .mark2    (mark2_reg),
        .esc      (esc_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .req      (req)
    );

    // unstuffed payload of the frame in progress
    sfd_ram #(
        .DATA_W (8),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // replays a good frame one result at a time
    sfd_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .busy       (busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_type   (out_type),
        .out_seq    (out_seq),
        .out_len    (out_len),
        .out_byte   (out_byte),
        .out_bvalid (out_bvalid),
        .out_last   (out_last)
    );

    assign m_tdata = {1'b0, out_byte, out_len, out_seq, out_type};
    assign m_tuser = out_bvalid;
    assign m_tlast = out_last;

endmodule

// File: src/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// port-level checks of the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sfd_pkg::TDATA_W-1:0]   m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // no input taken while a result is on offer
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // a stalled result keeps its payload
    a_stall_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a result with no byte (empty frame) ends its frame, with zero length
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[22:16] == 7'd0))
        else $error("empty frame result malformed");

    // data results carry a nonzero length
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[22:16] != 7'd0))
        else $error("data result with zero length");

    // input resumes right after the last result of a frame is taken
    a_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input not resumed after frame end");

endmodule

bind stuffed_crc_frame_decoder sfd_checker u_sfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/tb_stuffed_crc_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_stuffed_crc_frame_decoder
// streams framed serial bytes into the decoder under several marker and
// escape settings and compares every payload result with a built-in decoder
// ----------------------------------------------------------------------------
module tb_stuffed_crc_frame_decoder;

    import sfd_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES   = 12;    // quiet time before a register write
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;  // not a register

    // parser position of the built-in decoder
    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, READ_TYPE, READ_LEN,
        READ_SEQ, READ_BODY, READ_CRC_LO, READ_CRC_HI
    } rx_phase_t;

    typedef struct {
        logic [7:0]       ftype;
        logic [7:0]       seq;
        logic [LEN_W-1:0] len;
        logic [7:0]       pbyte;
        logic             bvalid;
        logic             last;
    } payload_result_t;

    // dut ports, all inputs known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;

    // register shadow
    logic [7:0] mark_first;
    logic [7:0] mark_second;
    logic [7:0] esc_val;

    // built-in decoder state
    rx_phase_t   rx_phase;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_len;
    logic [7:0]  hdr_seq;
    int          body_seen;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic        esc_armed;
    logic        overlong;
    logic [7:0]  kept_bytes[$];

    payload_result_t exp_payload_q[$];  // results still owed by the dut
    logic [7:0]      line_bytes_q[$];   // bytes waiting to go onto the input stream

    // handshakes seen at the last rising edge
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    bit src_idle = 1'b0;
    bit snk_idle = 1'b0;
    int src_wait = 0;
    int snk_wait = 0;
    int snk_draw;

    int bytes_queued    = 0;
    int bytes_taken     = 0;
    int results_checked = 0;
    int good_frames     = 0;
    int dropped_frames  = 0;
    int settings_used   = 0;
    int errors          = 0;
    int idle_cycles     = 0;

    stuffed_crc_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // built-in decoder
    // ------------------------------------------------------------------

    // crc16-ccitt, one data bit at a time, msb first
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void clear_frame();
        hdr_type  = '0;
        hdr_len   = '0;
        hdr_seq   = '0;
        body_seen = 0;
        crc_acc   = CRC_INIT;
        crc_lo    = '0;
        esc_armed = 1'b0;
        overlong  = 1'b0;
        kept_bytes.delete();
    endfunction

    function automatic void reset_decoder();
        mark_first  = MARK1_RESET;
        mark_second = MARK2_RESET;
        esc_val     = ESC_RESET;
        rx_phase    = HUNT_FIRST;
        clear_frame();
    endfunction

    function automatic void write_shadow(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        case (idx)
            CFG_MARK1: begin
                mark_first = v;
            end
            CFG_MARK2: begin
                mark_second = v;
            end
            CFG_ESC: begin
                esc_val = v;
            end
            default: begin
            end
        endcase
    endfunction

    // once the payload would pass the limit the frame is marked overlong
    function automatic void keep_byte(input logic [7:0] b);
        if (!overlong) begin
            if (kept_bytes.size() >= MAX_PAYLOAD_BYTES) begin
                overlong = 1'b1;
            end else begin
                kept_bytes.push_back(b);
            end
        end
    endfunction

    // one accepted input item; queues the results a good frame releases
    function automatic void decode_byte(input logic [7:0] b);
        payload_result_t r;
        case (rx_phase)
            HUNT_FIRST: begin
                if (b == mark_first) rx_phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                // a repeated first marker keeps waiting for the second
                if (b == mark_second) begin
                    clear_frame();
                    rx_phase = READ_TYPE;
                end else if (b != mark_first) begin
                    rx_phase = HUNT_FIRST;
                end
            end
            READ_TYPE: begin
                hdr_type = b;
                crc_acc  = crc_step(crc_acc, b);
                rx_phase = READ_LEN;
            end
            READ_LEN: begin
                hdr_len  = b;
                crc_acc  = crc_step(crc_acc, b);
                rx_phase = READ_SEQ;
            end
            READ_SEQ: begin
                hdr_seq  = b;
                crc_acc  = crc_step(crc_acc, b);
                rx_phase = (hdr_len == 0) ? READ_CRC_LO : READ_BODY;
            end
            READ_BODY: begin
                crc_acc = crc_step(crc_acc, b);
                body_seen++;
                if (esc_armed) begin
                    keep_byte(b ^ STUFF_XOR);
                    esc_armed = 1'b0;
                end else if (b == esc_val) begin
                    esc_armed = 1'b1;
                end else begin
                    keep_byte(b);
                end
                if (body_seen >= hdr_len) begin
                    // lone escape at the end of the body stays as it is
                    if (esc_armed) begin
                        keep_byte(esc_val);
                        esc_armed = 1'b0;
                    end
                    rx_phase = READ_CRC_LO;
                end
            end
            READ_CRC_LO: begin
                crc_lo   = b;
                rx_phase = READ_CRC_HI;
            end
            default: begin
                rx_phase = HUNT_FIRST;
                if ({b, crc_lo} == crc_acc && !overlong) begin
                    good_frames++;
                    r.ftype = hdr_type;
                    r.seq   = hdr_seq;
                    if (kept_bytes.size() == 0) begin
                        // empty payload still gives one marker result
                        r.len    = '0;
                        r.pbyte  = '0;
                        r.bvalid = 1'b0;
                        r.last   = 1'b1;
                        exp_payload_q.push_back(r);
                    end else begin
                        for (int i = 0; i < kept_bytes.size(); i++) begin
                            r.len    = LEN_W'(kept_bytes.size());
                            r.pbyte  = kept_bytes[i];
                            r.bvalid = 1'b1;
                            r.last   = (i == kept_bytes.size() - 1);
                            exp_payload_q.push_back(r);
                        end
                    end
                end else begin
                    dropped_frames++;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------
    // m_tdata: [7:0] frame_type, [15:8] frame_seq, [22:16] payload_len, [30:23] payload_byte
    function automatic void check_result();
        payload_result_t want;
        if (exp_payload_q.size() == 0) begin
            $error("unexpected result item, tdata %h", m_tdata);
            errors++;
        end else begin
            want = exp_payload_q.pop_front();
            if (m_tdata[7:0] !== want.ftype) begin
                $error("frame_type: expected %0d, got %0d", want.ftype, m_tdata[7:0]);
                errors++;
            end
            if (m_tdata[15:8] !== want.seq) begin
                $error("frame_seq: expected %0d, got %0d", want.seq, m_tdata[15:8]);
                errors++;
            end
            if (m_tdata[22:16] !== want.len) begin
                $error("payload_len: expected %0d, got %0d", want.len, m_tdata[22:16]);
                errors++;
            end
            if (m_tdata[30:23] !== want.pbyte) begin
                $error("payload_byte: expected %0d, got %0d", want.pbyte, m_tdata[30:23]);
                errors++;
            end
            if (m_tuser !== want.bvalid) begin
                $error("byte_valid: expected %0d, got %0d", want.bvalid, m_tuser);
                errors++;
            end
            if (m_tlast !== want.last) begin
                $error("last_of_frame: expected %0d, got %0d", want.last, m_tlast);
                errors++;
            end
        end
        results_checked++;
    endfunction

    // ------------------------------------------------------------------
    // monitor: everything sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_fire  <= aresetn && s_tvalid && s_tready;
        out_fire <= aresetn && m_tvalid && m_tready;
        if (!aresetn) begin
            reset_decoder();
            idle_cycles = 0;
        end else begin
            // register writes only land while no item is moving
            if (cfg_we) write_shadow(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) check_result();
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            // nothing moved for far longer than any replay or stall can take
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("timeout after %0d quiet cycles, %0d results still owed",
                         idle_cycles, exp_payload_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int draw_wait(input bit on);
        return on ? $urandom_range(0, 6) : 0;
    endfunction

    // ------------------------------------------------------------------
    // input driver: one byte per item, with idling on a random gap after each item
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else if (s_tvalid && !in_fire) begin
            // item not taken yet (payload replay stalls the input), hold it
        end else if (src_wait != 0) begin
            s_tvalid <= 1'b0;
            src_wait <= src_wait - 1;
        end else if (line_bytes_q.size() != 0) begin
            s_tdata  <= line_bytes_q.pop_front();
            s_tvalid <= 1'b1;
            src_wait <= draw_wait(src_idle);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result sink: with idling on, random stall after each accepted result item
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_wait <= 0;
        end else if (out_fire) begin
            snk_draw = draw_wait(snk_idle);
            m_tready <= (snk_draw == 0);
            snk_wait <= (snk_draw == 0) ? 0 : snk_draw - 1;
        end else if (snk_wait != 0) begin
            m_tready <= 1'b0;
            snk_wait <= snk_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        line_bytes_q.push_back(b);
        bytes_queued++;
    endfunction

    // markers, header, stuffed body and crc; esc_pct sets how often an
    // escape is placed, other bytes never equal the escape by chance
    function automatic void queue_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                                        input int slen, input int esc_pct,
                                        input bit trail_esc, input bit bad_crc);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [7:0]  b;
        for (int k = 0; k < slen; k++) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(1, 100) <= esc_pct) begin
                b = esc_val;
            end else if (b == esc_val) begin
                b = b ^ 8'h01;
            end
            body.push_back(b);
        end
        if (trail_esc && slen > 0) begin
            body[slen-1] = esc_val;
            if (slen > 1 && body[slen-2] == esc_val) body[slen-2] = esc_val ^ 8'h01;
        end
        crc = crc_step(CRC_INIT, ftype);
        crc = crc_step(crc, 8'(slen));
        crc = crc_step(crc, fseq);
        foreach (body[k]) crc = crc_step(crc, body[k]);
        if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        push_byte(mark_first);
        push_byte(mark_second);
        push_byte(ftype);
        push_byte(8'(slen));
        push_byte(fseq);
        foreach (body[k]) push_byte(body[k]);
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
    endfunction

    // mostly well-formed frames with random content, some noise, broken starts and bad crcs
    task automatic random_traffic(input int budget);
        int         stop_at;
        int         kind;
        int         slen;
        logic [7:0] b;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            kind = $urandom_range(0, 9);
            slen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            case (kind)
                0: begin
                    // line noise, mostly clear of the first marker
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 3) != 0 && b == mark_first) b = b ^ 8'h01;
                        push_byte(b);
                    end
                end
                1: begin
                    // first marker followed by a wrong second byte
                    b = mark_second ^ 8'h01;
                    if (b == mark_first) b = mark_second ^ 8'h02;
                    push_byte(mark_first);
                    push_byte(b);
                end
                2: begin
                    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                slen, 20, 0, 1);
                end
                3: begin
                    repeat ($urandom_range(1, 3)) push_byte(mark_first);
                    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                slen, 20, 0, 0);
                end
                4: begin
                    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                slen, 20, 1, 0);
                end
                default: begin
                    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                slen, 20, 0, 0);
                end
            endcase
        end
    endtask

    // all bytes taken, all results back, then a quiet settle period
    task automatic drain();
        while (bytes_taken != bytes_queued || exp_payload_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write the three registers back to back; the spare index must be ignored
    task automatic program_regs(input logic [7:0] m1, input logic [7:0] m2,
                                input logic [7:0] esc, input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MARK1;
        cfg_wdata <= m1;
        @(negedge aclk);
        cfg_index <= CFG_MARK2;
        cfg_wdata <= m2;
        @(negedge aclk);
        cfg_index <= CFG_ESC;
        cfg_wdata <= esc;
        @(negedge aclk);
        if (poke_spare) begin
            cfg_index <= CFG_IDX_SPARE;
            cfg_wdata <= ~m1;
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    initial begin
        logic [7:0] same_mark;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default markers, no idling: empty frame, marker resync with a
        // trailing escape, broken second marker, bad crc
        settings_used++;
        queue_frame(8'h00, 8'hFF, 0, 0, 0, 0);
        push_byte(mark_first);
        push_byte(mark_first);
        queue_frame(8'hFF, 8'h00, 3, 0, 1, 0);
        push_byte(mark_first);
        push_byte(8'h12);
        queue_frame(8'h5A, 8'hA5, 4, 50, 0, 1);
        drain();

        // low extremes; largest payload and one byte too many
        program_regs(8'h00, 8'hFF, 8'h00, 1'b1);
        src_idle = 1'b1;
        snk_idle = 1'b0;
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    MAX_PAYLOAD_BYTES, 0, 0, 0);
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    MAX_PAYLOAD_BYTES + 1, 0, 0, 0);
        drain();

        // high extremes, both sides idling
        program_regs(8'hFF, 8'h00, 8'hFF, 1'b0);
        snk_idle = 1'b1;
        random_traffic(6);
        drain();

        // both markers equal, random escape, only the sink stalls
        same_mark = 8'($urandom_range(0, 255));
        program_regs(same_mark, same_mark, 8'($urandom_range(0, 255)), 1'b0);
        src_idle = 1'b0;
        random_traffic(6);
        drain();

        // back to the reset values written explicitly
        program_regs(MARK1_RESET, MARK2_RESET, ESC_RESET, 1'b0);
        src_idle = 1'b1;
        random_traffic(6);
        drain();

        $display("sent %0d bytes under %0d marker/escape settings, with and without idling",
                 bytes_taken, settings_used);
        $display("%0d good frames, %0d dropped frames, %0d result items checked",
                 good_frames, dropped_frames, results_checked);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
